@@ rtl/uart8n1_pkg.sv @@
// ----------------------------------------------------------------------------
// uart8n1_pkg
// Shared types and constants for the 8N1 UART transmit/receive unit.
// ----------------------------------------------------------------------------
package uart8n1_pkg;

   // bit timer
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned RX_TICK_W = 17;

   localparam logic [TICK_W-1:0] BIT_TICKS_RESET = 16'd1667;
   localparam logic [TICK_W-1:0] BIT_TICKS_MIN   = 16'd4;

   // stream payload widths
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam int unsigned BYTE_W      = 8;

   // transmit phase codes; data bits follow start, stop bit is last
   localparam int unsigned TX_PHASE_W = 4;
   localparam logic [TX_PHASE_W-1:0] TX_PHASE_IDLE  = 4'd0;
   localparam logic [TX_PHASE_W-1:0] TX_PHASE_START = 4'd1;
   localparam logic [TX_PHASE_W-1:0] TX_PHASE_DATA0 = 4'd2;

   // receive phase
   typedef enum logic [1:0] {
      RX_IDLE = 2'd0,
      RX_RECV = 2'd1,
      RX_WAIT = 2'd2
   } rx_phase_type;

endpackage

@@ rtl/uart_8n1_tx_rx_unit.sv @@
// ----------------------------------------------------------------------------
// uart_8n1_tx_rx_unit
// Bit-timed 8N1 UART transmitter and receiver, one stream item per bit-timer
// tick.
// ----------------------------------------------------------------------------
// Each accepted req item is one tick of the bit timer. The unit takes one item
// every clock cycle while the rsp side is not stalled and returns exactly one
// rsp item per req item, in the cycle after acceptance, from the single result
// register; a stalled rsp side thus also holds off req (req is taken whenever
// the result register is empty or being drained in the same cycle).
// Transmit: a req with tuser set while the transmitter is idle starts a frame
// (low start bit, DATA_BITS data bits LSB first, high stop bit), each bit
// csr_wr_data ticks long; the requesting tick is already the first start-bit
// tick. Requests while busy are dropped. Receive: a low rx_line while idle is
// the start edge; bits are sampled 1.5, 2.5, ... bit periods later, the byte
// is reported with rx_done for one tick, then the receiver waits for a high
// line. No framing check. Bit periods below 4 ticks behave as 4 ticks.
// ----------------------------------------------------------------------------
module uart_8n1_tx_rx_unit #(
   parameter int unsigned DATA_BITS = 8   // 5..8
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // req_tdata: [7:0] tx_byte, [8] rx_line, [15:9] zero
   // req_tuser: action (1 = request transmit of tx_byte)
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [uart8n1_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                  req_tuser,

   // rsp_tdata: [0] tx_line, [1] tx_busy, [9:2] rx_byte, [10] rx_done,
   //            [15:11] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [uart8n1_pkg::RSP_TDATA_W-1:0]   rsp_tdata,

   // bit_ticks register
   input  logic                                  csr_wr_en,
   input  logic [uart8n1_pkg::TICK_W-1:0]        csr_wr_data
);
   import uart8n1_pkg::*;

   localparam logic [TX_PHASE_W-1:0] TX_LAST_DATA = TX_PHASE_W'(DATA_BITS + 1);
   localparam logic [TX_PHASE_W-1:0] TX_STOP      = TX_PHASE_W'(DATA_BITS + 2);
   localparam logic [3:0]            RX_NBITS     = 4'(DATA_BITS);

   // configuration
   logic [TICK_W-1:0]     bit_ticks_ff;

   // transmitter state
   logic [DATA_BITS-1:0]  tx_shift_ff,   tx_shift_in;
   logic [TX_PHASE_W-1:0] tx_phase_ff,   tx_phase_in;
   logic [TICK_W-1:0]     tx_count_ff,   tx_count_in;

   // receiver state
   rx_phase_type          rx_phase_ff,   rx_phase_in;
   logic [3:0]            rx_bits_ff,    rx_bits_in;
   logic [RX_TICK_W-1:0]  rx_count_ff,   rx_count_in;
   logic [DATA_BITS-1:0]  rx_shift_ff,   rx_shift_in;
   logic [BYTE_W-1:0]     rx_hold_ff,    rx_hold_in;

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff,  rsp_data_in;

   // per-item working signals
   logic                  accept;
   logic                  action;
   logic [BYTE_W-1:0]     tx_byte;
   logic                  rx_line;
   logic [TICK_W-1:0]     period;
   logic [TICK_W-1:0]     tx_count_inc;
   logic [RX_TICK_W-1:0]  rx_target;
   logic [RX_TICK_W-1:0]  rx_count_inc;
   logic [3:0]            rx_bits_inc;
   logic                  rx_done;
   logic                  tx_line;

   assign action  = req_tuser;
   assign tx_byte = req_tdata[BYTE_W-1:0];
   assign rx_line = req_tdata[BYTE_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign period = (bit_ticks_ff < BIT_TICKS_MIN) ? BIT_TICKS_MIN : bit_ticks_ff;

   // transmitter: count ticks in the current bit, step phase at period
   assign tx_count_inc = tx_count_ff + 1'b1;

   always_comb begin
      tx_shift_in = tx_shift_ff;
      tx_phase_in = tx_phase_ff;
      tx_count_in = tx_count_ff;
      if (tx_phase_ff == TX_PHASE_IDLE) begin
         if (action) begin
            tx_shift_in = tx_byte[DATA_BITS-1:0];
            tx_phase_in = TX_PHASE_START;
            tx_count_in = '0;
         end
      end else if (tx_count_inc >= period) begin
         tx_count_in = '0;
         if (tx_phase_ff >= TX_PHASE_DATA0 && tx_phase_ff <= TX_LAST_DATA) begin
            tx_shift_in = tx_shift_ff >> 1;
         end
         tx_phase_in = (tx_phase_ff >= TX_STOP) ? TX_PHASE_IDLE
                                                 : tx_phase_ff + 1'b1;
      end else begin
         tx_count_in = tx_count_inc;
      end
   end

   // line level after this tick's update
   always_comb begin
      if (tx_phase_in == TX_PHASE_IDLE || tx_phase_in > TX_LAST_DATA) begin
         tx_line = 1'b1;
      end else if (tx_phase_in == TX_PHASE_START) begin
         tx_line = 1'b0;
      end else begin
         tx_line = tx_shift_in[0];
      end
   end

   // receiver: first sample waits 1.5 periods, later ones one period
   assign rx_target    = (rx_bits_ff == '0)
                         ? {1'b0, period} + RX_TICK_W'(period >> 1)
                         : {1'b0, period};
   assign rx_count_inc = rx_count_ff + 1'b1;
   assign rx_bits_inc  = rx_bits_ff + 1'b1;

   always_comb begin
      rx_phase_in = rx_phase_ff;
      rx_bits_in  = rx_bits_ff;
      rx_count_in = rx_count_ff;
      rx_shift_in = rx_shift_ff;
      rx_hold_in  = rx_hold_ff;
      rx_done     = 1'b0;
      case (rx_phase_ff)
         RX_IDLE: begin
            if (!rx_line) begin
               rx_phase_in = RX_RECV;
               rx_count_in = '0;
               rx_bits_in  = '0;
            end
         end
         RX_RECV: begin
            if (rx_count_inc < rx_target) begin
               rx_count_in = rx_count_inc;
            end else begin
               rx_count_in = '0;
               rx_shift_in = {rx_line, rx_shift_ff[DATA_BITS-1:1]};
               rx_bits_in  = rx_bits_inc;
               if (rx_bits_inc >= RX_NBITS) begin
                  rx_hold_in  = BYTE_W'(rx_shift_in);
                  rx_bits_in  = '0;
                  rx_phase_in = RX_WAIT;
                  rx_done     = 1'b1;
               end
            end
         end
         default: begin
            // waiting for the line to return high
            if (rx_line) begin
               rx_phase_in = RX_IDLE;
            end
         end
      endcase
   end

   assign rsp_data_in = {5'b0, rx_done, rx_hold_in, (tx_phase_in != TX_PHASE_IDLE),
                         tx_line};

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_TICKS_RESET;
         tx_shift_ff  <= '0;
         tx_phase_ff  <= TX_PHASE_IDLE;
         tx_count_ff  <= '0;
         rx_phase_ff  <= RX_IDLE;
         rx_bits_ff   <= '0;
         rx_count_ff  <= '0;
         rx_shift_ff  <= '0;
         rx_hold_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            bit_ticks_ff <= csr_wr_data;
         end
         if (accept) begin
            tx_shift_ff  <= tx_shift_in;
            tx_phase_ff  <= tx_phase_in;
            tx_count_ff  <= tx_count_in;
            rx_phase_ff  <= rx_phase_in;
            rx_bits_ff   <= rx_bits_in;
            rx_count_ff  <= rx_count_in;
            rx_shift_ff  <= rx_shift_in;
            rx_hold_ff   <= rx_hold_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ tb/uart_8n1_pin_checker.sv @@
// ----------------------------------------------------------------------------
// uart_8n1_pin_checker
// Watches the req, rsp and csr ports of the UART unit, predicts the pin levels
// and received byte of every tick and compares each rsp item with them.
// ----------------------------------------------------------------------------
module uart_8n1_pin_checker #(
   parameter int unsigned DATA_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [uart8n1_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [uart8n1_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [uart8n1_pkg::TICK_W-1:0]        csr_wr_data,
   output int                                    fail_count,
   output int                                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import uart8n1_pkg::*;

   localparam logic [BYTE_W-1:0] DATA_MASK = BYTE_W'((1 << DATA_BITS) - 1);
   localparam int unsigned TX_PHASE_STOP = TX_PHASE_DATA0 + DATA_BITS;

   typedef struct packed {
      logic              rx_done;
      logic [BYTE_W-1:0] rx_byte;
      logic              tx_busy;
      logic              tx_line;
   } pin_state_type;

   // predicted unit state
   logic [TICK_W-1:0]     bit_ticks;
   logic [BYTE_W-1:0]     tx_shift;
   logic [TX_PHASE_W-1:0] tx_phase;
   logic [TICK_W-1:0]     tx_ticks;
   rx_phase_type          rx_phase;
   logic [3:0]            rx_bits;
   logic [RX_TICK_W-1:0]  rx_ticks;
   logic [BYTE_W-1:0]     rx_shift;
   logic [BYTE_W-1:0]     rx_hold;

   pin_state_type expected_pins[$];
   pin_state_type want;
   pin_state_type got;

   // one bit-timer tick of both directions
   function automatic pin_state_type advance_uart(input logic action,
                                                  input logic [BYTE_W-1:0] tx_data,
                                                  input logic line);
      int unsigned   bt;
      int unsigned   target;
      pin_state_type pins;
      bt = (bit_ticks < BIT_TICKS_MIN) ? BIT_TICKS_MIN : bit_ticks;
      pins.rx_done = 1'b0;

      if (tx_phase == TX_PHASE_IDLE) begin
         if (action) begin
            tx_shift = tx_data;
            tx_phase = TX_PHASE_START;
            tx_ticks = '0;
         end
      end else begin
         tx_ticks = tx_ticks + 1'b1;
         if (tx_ticks >= bt) begin
            tx_ticks = '0;
            if (tx_phase >= TX_PHASE_DATA0 && tx_phase < TX_PHASE_STOP)
               tx_shift = tx_shift >> 1;
            tx_phase = (tx_phase == TX_PHASE_STOP) ? TX_PHASE_IDLE : tx_phase + 1'b1;
         end
      end

      case (rx_phase)
         RX_IDLE: begin
            if (!line) begin
               rx_phase = RX_RECV;
               rx_ticks = '0;
               rx_bits  = '0;
            end
         end
         RX_RECV: begin
            // first sample lands mid data bit 0, 1.5 periods past the edge
            target   = (rx_bits == 0) ? bt + (bt >> 1) : bt;
            rx_ticks = rx_ticks + 1'b1;
            if (rx_ticks >= target) begin
               rx_ticks = '0;
               rx_shift = (rx_shift >> 1) | ({7'b0, line} << (DATA_BITS - 1));
               rx_bits  = rx_bits + 1'b1;
               if (rx_bits >= DATA_BITS) begin
                  rx_hold      = rx_shift & DATA_MASK;
                  rx_bits      = '0;
                  rx_phase     = RX_WAIT;
                  pins.rx_done = 1'b1;
               end
            end
         end
         default: begin
            if (line)
               rx_phase = RX_IDLE;
         end
      endcase

      if (tx_phase == TX_PHASE_IDLE || tx_phase >= TX_PHASE_STOP)
         pins.tx_line = 1'b1;
      else if (tx_phase == TX_PHASE_START)
         pins.tx_line = 1'b0;
      else
         pins.tx_line = tx_shift[0];
      pins.tx_busy = (tx_phase != TX_PHASE_IDLE);
      pins.rx_byte = rx_hold;
      return pins;
   endfunction

   task automatic check_field(input string field, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: rsp %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bit_ticks = BIT_TICKS_RESET;
         tx_shift  = '0;
         tx_phase  = TX_PHASE_IDLE;
         tx_ticks  = '0;
         rx_phase  = RX_IDLE;
         rx_bits   = '0;
         rx_ticks  = '0;
         rx_shift  = '0;
         rx_hold   = '0;
         expected_pins.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[10], rsp_tdata[9:2], rsp_tdata[1], rsp_tdata[0]};
            if (expected_pins.size() == 0) begin
               $display("%0t: rsp item with none expected, actual 0x%0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_pins.pop_front();
               check_field("tx_line", 32'(want.tx_line), 32'(got.tx_line));
               check_field("tx_busy", 32'(want.tx_busy), 32'(got.tx_busy));
               check_field("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
               check_field("rx_done", 32'(want.rx_done), 32'(got.rx_done));
               check_field("pad", 0, 32'(rsp_tdata[RSP_TDATA_W-1:11]));
            end
         end
         if (csr_wr_en)
            bit_ticks = csr_wr_data;
         if (req_tvalid && req_tready)
            expected_pins.push_back(advance_uart(req_tuser, req_tdata[7:0], req_tdata[8]));
      end
      outstanding = expected_pins.size();
   end

endmodule

@@ tb/tb_uart_8n1_tx_rx_unit.sv @@
// ----------------------------------------------------------------------------
// tb_uart_8n1_tx_rx_unit
// Drives tick items into the UART unit: a short directed run over the period
// extremes, then phases of framed, broken and noisy rx traffic with random
// transmit requests, each phase after its own bit period write. The pin checker
// predicts and compares every rsp item; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_uart_8n1_tx_rx_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import uart8n1_pkg::*;

   localparam int unsigned QUIET_LIMIT  = 2000;  // cycles without any handshake or register write
   localparam int unsigned PHASE_ITEMS  = 120;
   localparam int unsigned PHASE_COUNT  = 8;
   // bit period per random phase; 3 and 0 exercise the 4-tick floor
   localparam int unsigned PHASE_TICKS [PHASE_COUNT] = '{4, 5, 3, 8, 0, 13, 6, 4};
   // 1-in-(n+1) odds of a transmit request per tick; 0 requests every tick
   localparam int unsigned PHASE_ODDS [PHASE_COUNT]  = '{24, 2, 0, 8, 40, 4, 1, 10};

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata   = '0;
   logic                     req_tuser   = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b1;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     csr_wr_en   = 1'b0;
   logic [TICK_W-1:0]        csr_wr_data = '0;

   int          fail_count;
   int          outstanding;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left   = 0;
   bit          req_idle_on  = 1'b1;
   bit          rsp_idle_on  = 1'b1;
   int unsigned cur_ticks    = BIT_TICKS_RESET;  // period the rx traffic is shaped for
   bit          rx_plan[$];                      // rx_line level per upcoming tick

   always #5 clock = ~clock;

   uart_8n1_tx_rx_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   uart_8n1_pin_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("** uart_8n1_tx_rx_unit: FAILED **");
      $finish;
   end

   // rsp side back-pressure: random bursts of rsp_tready low, begun only while enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // One tick item; may be preceded by a sender gap. Returns right after the
   // edge that accepted it, with tvalid still high.
   task automatic send_item(input logic action, input logic [BYTE_W-1:0] tx_data,
                            input logic line);
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {{(REQ_TDATA_W-9){1'b0}}, line, tx_data};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and hold until every predicted rsp item has been seen.
   task automatic wait_results_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Register write only with nothing in flight.
   task automatic write_bit_ticks(input logic [TICK_W-1:0] value);
      wait_results_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cur_ticks    = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Queue up the next stretch of rx line levels. Mostly clean 8N1 frames
   // with random data; the rest are jittered frames, breaks (line held low,
   // no stop bit), random noise and short low glitches.
   task automatic plan_rx_traffic();
      int unsigned       bt;
      int unsigned       kind;
      logic [BYTE_W-1:0] data;
      bt   = (cur_ticks < BIT_TICKS_MIN) ? BIT_TICKS_MIN : cur_ticks;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         repeat ($urandom_range(0, 2 * bt)) rx_plan.push_back(1'b1);
         data = BYTE_W'($urandom);
         repeat (bt) rx_plan.push_back(1'b0);
         for (int i = 0; i < BYTE_W; i++) begin
            // jittered frames stretch or shrink each data bit by up to one tick
            repeat ((kind == 6) ? bt - 1 + $urandom_range(0, 2) : bt)
               rx_plan.push_back(data[i]);
         end
         repeat (bt) rx_plan.push_back(1'b1);
      end else if (kind == 7) begin
         repeat ($urandom_range(bt, 12 * bt)) rx_plan.push_back(1'b0);
         repeat ($urandom_range(1, bt)) rx_plan.push_back(1'b1);
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 3 * bt)) rx_plan.push_back(1'($urandom_range(0, 1)));
      end else begin
         repeat ($urandom_range(1, 2)) rx_plan.push_back(1'b0);
         repeat (bt) rx_plan.push_back(1'b1);
      end
   endtask

   // count random ticks; rx line follows the plan, tx requests by the odds
   task automatic run_ticks(input int unsigned count, input int unsigned odds);
      logic line;
      for (int unsigned n = 0; n < count; n++) begin
         if (rx_plan.size() == 0)
            plan_rx_traffic();
         line = rx_plan.pop_front();
         send_item($urandom_range(0, odds) == 0, BYTE_W'($urandom), line);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: at the reset period start a frame of all ones, try a
      // request while busy and open an rx start edge.
      send_item(1'b1, 8'hFF, 1'b1);
      send_item(1'b1, 8'h00, 1'b0);
      send_item(1'b0, 8'hA5, 1'b1);

      // Longest period mid-frame on both sides.
      write_bit_ticks(16'hFFFF);
      send_item(1'b0, 8'h5A, 1'b0);
      send_item(1'b1, 8'hFF, 1'b1);
      send_item(1'b0, 8'h00, 1'b1);

      // Shortest legal period: the tx counter is already past it, so the current
      // tx bit ends on the next tick.
      write_bit_ticks(BIT_TICKS_MIN);
      for (int i = 0; i < 18; i++)
         send_item(i % 3 == 0, (i % 2 == 0) ? 8'h00 : 8'hFF, (i / 4) % 2 == 0);

      // Random phases; each register write lands wherever the frames are.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_bit_ticks(PHASE_TICKS[p]);
         // phase 2 is a stretch with no idling; the last phase has none either
         req_idle_on = (p != 2) && (p != PHASE_COUNT - 1);
         rsp_idle_on = req_idle_on;
         run_ticks(PHASE_ITEMS, PHASE_ODDS[p]);
      end

      wait_results_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("** uart_8n1_tx_rx_unit: PASSED **");
      else
         $display("** uart_8n1_tx_rx_unit: FAILED **");
      $finish;
   end

endmodule
